/* rtl/pdst_pkg.sv */
// ============================================================================
// pdst_pkg
// Shared types, constants and helpers for the stress tensor accumulator.
// ============================================================================
package pdst_pkg;

    localparam int PAIR_CAPACITY = 256;
    localparam int CNT_W         = $clog2(PAIR_CAPACITY + 1);

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_PAIR  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // search token travelling down the cell row
    typedef struct packed {
        logic        active;
        logic [31:0] key;
        logic [31:0] rev;
        logic        hit;
    } t_probe;

    // one write or clear broadcast to all cells
    typedef struct packed {
        logic             wr;
        logic             clr;
        logic [CNT_W-1:0] idx;
        logic [31:0]      key;
    } t_cell_ctl;

    // signed 64-bit saturating add
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63])
            sat_add = {1'b0, {63{1'b1}}};
        else if (a[63] && b[63] && !s[63])
            sat_add = {1'b1, 63'd0};
        else
            sat_add = s;
    endfunction

endpackage

/* rtl/pair_deduplicated_stress_tensor_top.sv */
// ============================================================================
// pair_deduplicated_stress_tensor_top
// Virial stress tensor accumulator with pair de-duplication.
// ============================================================================
// One beat in, one beat out, one item at a time. A clear or unused command
// goes straight to the output load; an add without pair makes three row
// passes through one 3-lane multiplier, the saturating add of the last row,
// then the output load; an add with pair check first walks the probe down
// the row of table cells one cell per cycle, then either rejects the pair
// and loads the output or accumulates it as an add does. The result beat
// turns valid in the same cycle that the input is ready again. A result left
// waiting in the output register does not hold off the input; only a second
// finished result waits for it to leave.
module pair_deduplicated_stress_tensor_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[1:0], force_x, force_y, force_z, dist_x, dist_y, dist_z,
    // id_first[15:0], id_second[15:0], 6 zero bits
    input  logic [231:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // s_xx, s_xy, s_xz, s_yx, s_yy, s_yz, s_zx, s_zy, s_zz,
    // duplicate, is_empty, table_full, 5 zero bits
    output logic [583:0] m_axis_tdata
);
    import pdst_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_DECIDE, S_MAC, S_OUT} t_state;

    t_state             r_state;
    logic signed [31:0] r_f [3];
    logic signed [31:0] r_d [3];
    logic [31:0]        r_key;
    logic [CNT_W-1:0]   r_count;
    logic               r_empty, r_dup, r_full, r_ovalid;
    logic [CNT_W-1:0]   r_wait;
    logic               mac_start, mac_done;
    logic signed [63:0] sum [9];
    t_cell_ctl          ctl;
    t_probe             probe [PAIR_CAPACITY+1];
    logic               in_fire;
    logic               out_load;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_load      = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);

    // probe enters the row on accept of a pair add
    always_comb begin
        probe[0].active = in_fire && t_cmd'(s_axis_tdata[1:0]) == CMD_PAIR;
        probe[0].key    = {s_axis_tdata[209:194], s_axis_tdata[225:210]};
        probe[0].rev    = {s_axis_tdata[225:210], s_axis_tdata[209:194]};
        probe[0].hit    = 1'b0;
    end

    // table write broadcast; the clear line is held low
    always_comb begin
        ctl.wr  = (r_state == S_DECIDE) && !probe[PAIR_CAPACITY].hit &&
                  (r_count < CNT_W'(PAIR_CAPACITY));
        ctl.clr = 1'b0;
        ctl.idx = r_count;
        ctl.key = r_key;
    end

    for (genvar g = 0; g < PAIR_CAPACITY; g++) begin : g_cell
        pdst_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_my_idx(CNT_W'(g)),
            .i_count (r_count),
            .i_ctl   (ctl),
            .i_probe (probe[g]),
            .o_probe (probe[g+1])
        );
    end

    pdst_mac u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mac_start),
        .i_clear(r_state == S_IDLE && in_fire && t_cmd'(s_axis_tdata[1:0]) == CMD_CLEAR),
        .i_f    (r_f),
        .i_d    (r_d),
        .o_done (mac_done),
        .o_sum  (sum)
    );

    assign mac_start = (in_fire && t_cmd'(s_axis_tdata[1:0]) == CMD_ADD) ||
                       ctl.wr;

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_empty  <= 1'b1;
            r_ovalid <= 1'b0;
            r_dup    <= 1'b0;
            r_full   <= 1'b0;
        end else begin
            // output register: load a finished result, drop it once taken
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_key <= probe[0].key;
                        r_dup  <= 1'b0;
                        r_full <= 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            r_f[i] <= s_axis_tdata[2+32*i +: 32];
                            r_d[i] <= s_axis_tdata[98+32*i +: 32];
                        end
                        r_wait <= '0;
                        case (t_cmd'(s_axis_tdata[1:0]))
                            CMD_ADD:   r_state <= S_MAC;
                            CMD_PAIR:  r_state <= S_SEARCH;
                            CMD_CLEAR: begin
                                r_count <= '0;
                                r_empty <= 1'b1;
                                r_state <= S_OUT;
                            end
                            default:   r_state <= S_OUT;
                        endcase
                    end
                end
                S_SEARCH: begin
                    // probe leaves the last cell on the edge that moves to S_DECIDE
                    r_wait <= r_wait + CNT_W'(1);
                    if (r_wait == CNT_W'(PAIR_CAPACITY - 2)) r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (probe[PAIR_CAPACITY].hit) begin
                        r_dup   <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_count >= CNT_W'(PAIR_CAPACITY)) begin
                        r_full  <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_count <= r_count + CNT_W'(1);
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (mac_done) begin
                        r_empty <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            for (int k = 0; k < 9; k++) m_axis_tdata[64*k +: 64] <= sum[k];
            m_axis_tdata[583:576] <= {5'd0, r_full, r_empty, r_dup};
        end
    end
    assign m_axis_tvalid = r_ovalid;

    // checks
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[576] && m_axis_tdata[578]))
        else $error("duplicate and full together");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PAIR_CAPACITY)) else $error("pair count overflow");

endmodule

/* rtl/pdst_cell.sv */
// ============================================================================
// pdst_cell
// One pair table slot; compares the passing probe and forwards it.
// ============================================================================
module pdst_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [pdst_pkg::CNT_W-1:0] i_my_idx,
    input  logic [pdst_pkg::CNT_W-1:0] i_count,
    input  pdst_pkg::t_cell_ctl i_ctl,
    input  pdst_pkg::t_probe    i_probe,
    output pdst_pkg::t_probe    o_probe
);
    import pdst_pkg::*;

    logic [31:0] r_entry;
    logic        match;

    // entry store
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && i_ctl.idx == i_my_idx) begin
            r_entry <= i_ctl.key;
        end
    end

    // only entries below the fill count take part
    assign match = (i_my_idx < i_count) &&
                   (r_entry == i_probe.key || r_entry == i_probe.rev);

    // probe hand-on register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            o_probe.active <= 1'b0;
        end else begin
            o_probe.active <= i_probe.active;
        end
        o_probe.key <= i_probe.key;
        o_probe.rev <= i_probe.rev;
        o_probe.hit <= i_probe.hit | (i_probe.active & match);
    end

endmodule

/* rtl/pdst_mac.sv */
// ============================================================================
// pdst_mac
// Three 32x32 multipliers shared by the rows, three products per row, saturating accumulate.
// ============================================================================
module pdst_mac (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_clear,
    input  logic signed [31:0] i_f [3],
    input  logic signed [31:0] i_d [3],
    output logic               o_done,
    output logic signed [63:0] o_sum [9]
);
    import pdst_pkg::*;

    logic signed [63:0] r_sum [9];
    logic signed [63:0] r_prod [3];
    logic [1:0]         r_row;
    logic               r_run;
    logic               r_acc;
    logic [1:0]         r_acc_row;
    logic               r_done;

    // row sequencer and product registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_acc  <= 1'b0;
            r_done <= 1'b0;
            r_row  <= 2'd0;
        end else begin
            r_done <= r_acc && r_acc_row == 2'd2;
            r_acc  <= r_run;
            if (i_start) begin
                r_run <= 1'b1;
                r_row <= 2'd0;
            end else if (r_run) begin
                if (r_row == 2'd2) begin
                    r_run <= 1'b0;
                    r_row <= 2'd0;
                end else begin
                    r_row <= r_row + 2'd1;
                end
            end
        end
        r_acc_row <= r_row;
        for (int c = 0; c < 3; c++) begin
            r_prod[c] <= i_f[r_row] * i_d[c];
        end
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int k = 0; k < 9; k++) r_sum[k] <= '0;
        end else if (r_acc) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[r_acc_row*3+c] <= sat_add(r_sum[r_acc_row*3+c], r_prod[c]);
            end
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;

endmodule

/* sim/tb_pair_deduplicated_stress_tensor_top.sv */
// ============================================================================
// tb_pair_deduplicated_stress_tensor_top
// Self-checking bench for the pair de-duplicated stress tensor accumulator.
// A directed table and then random traffic drive the input stream. Each beat
// is fed through a local model of the tensor, the pair table and the flags.
// Every output beat is checked against the oldest predicted result.
// ============================================================================
module tb_pair_deduplicated_stress_tensor_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pdst_pkg::*;

    localparam int  N_RANDOM    = 1325;
    localparam longint CYC_LIMIT = 3000000;
    localparam int  DRAIN_CYC   = 300;

    typedef struct {
        t_cmd               cmd;
        logic signed [31:0] f [3];
        logic signed [31:0] d [3];
        logic [15:0]        id_a;
        logic [15:0]        id_b;
        bit                 chk_zero;   // typed expectation: cleared tensor
    } t_item;

    typedef struct {
        logic [63:0] s [9];
        logic        dup;
        logic        emp;
        logic        full;
    } t_tensor_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [231:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [583:0] m_axis_tdata;

    pair_deduplicated_stress_tensor_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // local copy of the block state
    logic signed [63:0] mdl_tensor [9];
    logic [31:0]        mdl_pairs [$];
    bit                 mdl_empty;

    t_tensor_res tensor_q [$];
    t_item       directed [$];
    int          err_cnt = 0;
    longint      cyc = 0;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < -65'sh0_8000_0000_0000_0000)
            return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    // predict one result and advance the local state
    function automatic t_tensor_res predict_tensor(input t_item it);
        t_tensor_res r;
        logic [31:0] key, rev;
        bit hit;
        bit acc;
        hit = 1'b0;
        acc = 1'b0;
        r.dup = 1'b0;
        r.full = 1'b0;
        case (it.cmd)
            CMD_ADD: acc = 1'b1;
            CMD_PAIR: begin
                key = {it.id_a, it.id_b};
                rev = {it.id_b, it.id_a};
                foreach (mdl_pairs[i])
                    if (mdl_pairs[i] == key || mdl_pairs[i] == rev) hit = 1'b1;
                if (hit) r.dup = 1'b1;
                else if (mdl_pairs.size() >= PAIR_CAPACITY) r.full = 1'b1;
                else begin
                    mdl_pairs.insert(mdl_pairs.size(), key);
                    acc = 1'b1;
                end
            end
            CMD_CLEAR: begin
                foreach (mdl_tensor[k]) mdl_tensor[k] = '0;
                mdl_pairs.delete();
                mdl_empty = 1'b1;
            end
            default: ;
        endcase
        if (acc) begin
            for (int rr = 0; rr < 3; rr++)
                for (int cc = 0; cc < 3; cc++)
                    mdl_tensor[rr*3+cc] = clamp_add(mdl_tensor[rr*3+cc],
                        64'(it.f[rr]) * 64'(it.d[cc]));
            mdl_empty = 1'b0;
        end
        foreach (r.s[k]) r.s[k] = mdl_tensor[k];
        r.emp = mdl_empty;
        return r;
    endfunction

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4, 5: return 32'($signed($urandom_range(0, 8'hFF)) - 128) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item rand_item(input t_cmd cmd, input int id_span);
        t_item it;
        it.cmd = cmd;
        for (int k = 0; k < 3; k++) begin
            it.f[k] = rand_q16();
            it.d[k] = rand_q16();
        end
        if (id_span > 0) begin
            it.id_a = 16'($urandom_range(0, id_span));
            it.id_b = 16'($urandom_range(0, id_span));
        end else begin
            it.id_a = 16'($urandom);
            it.id_b = 16'($urandom);
        end
        it.chk_zero = 1'b0;
        return it;
    endfunction

    task automatic add_row(input t_cmd cmd, input logic [31:0] fv, input logic [31:0] dv,
                           input logic [15:0] a, input logic [15:0] b, input bit chk);
        t_item it;
        it.cmd = cmd;
        for (int k = 0; k < 3; k++) begin
            it.f[k] = fv;
            it.d[k] = dv;
        end
        it.id_a = a;
        it.id_b = b;
        it.chk_zero = chk;
        directed.insert(directed.size(), it);
    endtask

    // sender: bursts of beats with random gaps between them
    int burst_left = 0;

    task automatic send_beat(input t_item it);
        t_tensor_res exp_r;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {6'd0, it.id_b, it.id_a, it.d[2], it.d[1], it.d[0],
                         it.f[2], it.f[1], it.f[0], it.cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        exp_r = predict_tensor(it);
        if (it.chk_zero && (exp_r.s[0] != 0 || exp_r.s[8] != 0 || !exp_r.emp))
            report("directed row expected a cleared tensor");
        tensor_q.insert(tensor_q.size(), exp_r);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // receiver: stall pattern steps through four modes in turn
    always @(negedge i_clk) begin
        case ((cyc / 400) % 4)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 9) < 7);
            2: m_axis_tready <= (cyc % 8) > 2;
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // output check against the oldest prediction
    always @(posedge i_clk) begin
        t_tensor_res e;
        cyc <= cyc + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tensor_q.size() == 0) begin
                report("output beat with no prediction waiting");
            end else begin
                e = tensor_q.pop_front();
                for (int k = 0; k < 9; k++)
                    if (m_axis_tdata[k*64 +: 64] !== e.s[k])
                        report($sformatf("element %0d got %h want %h", k,
                               m_axis_tdata[k*64 +: 64], e.s[k]));
                if (m_axis_tdata[576] !== e.dup)
                    report($sformatf("duplicate got %b want %b", m_axis_tdata[576], e.dup));
                if (m_axis_tdata[577] !== e.emp)
                    report($sformatf("is_empty got %b want %b", m_axis_tdata[577], e.emp));
                if (m_axis_tdata[578] !== e.full)
                    report($sformatf("table_full got %b want %b", m_axis_tdata[578], e.full));
            end
        end
        if (cyc > CYC_LIMIT) begin
            $display("[pair_deduplicated_stress_tensor_top] ERROR");
            $finish;
        end
    end

    initial begin
        t_item it;
        int sent;
        int rnd;
        foreach (mdl_tensor[k]) mdl_tensor[k] = '0;
        mdl_empty = 1'b1;

        // directed table
        add_row(CMD_NONE,  32'h1234_5678, 32'h1, 16'd0, 16'd0, 1'b1);
        add_row(CMD_CLEAR, 32'h0, 32'h0, 16'd0, 16'd0, 1'b1);
        add_row(CMD_ADD,   32'h8000_0000, 32'h8000_0000, 16'd0, 16'd0, 1'b0);
        add_row(CMD_ADD,   32'h8000_0000, 32'h8000_0000, 16'd0, 16'd0, 1'b0);
        add_row(CMD_ADD,   32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 16'd0, 1'b0);
        add_row(CMD_CLEAR, 32'h0, 32'h0, 16'd0, 16'd0, 1'b1);
        add_row(CMD_ADD,   32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 16'd0, 1'b0);
        add_row(CMD_ADD,   32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 16'd0, 1'b0);
        add_row(CMD_ADD,   32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 16'd0, 1'b0);
        add_row(CMD_ADD,   32'h0, 32'h7FFF_FFFF, 16'd0, 16'd0, 1'b0);
        add_row(CMD_PAIR,  32'hFFFF_FFFF, 32'h0001_0000, 16'd1, 16'd2, 1'b0);
        add_row(CMD_PAIR,  32'h0001_0000, 32'h0001_0000, 16'd2, 16'd1, 1'b0);
        add_row(CMD_PAIR,  32'h0001_0000, 32'h0001_0000, 16'd1, 16'd2, 1'b0);
        add_row(CMD_PAIR,  32'h0002_0000, 32'hFFFF_0000, 16'd7, 16'd7, 1'b0);
        add_row(CMD_PAIR,  32'h0002_0000, 32'hFFFF_0000, 16'd7, 16'd7, 1'b0);
        add_row(CMD_PAIR,  32'h1, 32'h1, 16'hFFFF, 16'h0000, 1'b0);
        add_row(CMD_PAIR,  32'h1, 32'h1, 16'h0000, 16'hFFFF, 1'b0);
        add_row(CMD_NONE,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd3, 16'd4, 1'b0);
        add_row(CMD_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 16'd0, 1'b0);
        add_row(CMD_CLEAR, 32'h0, 32'h0, 16'd0, 16'd0, 1'b1);

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) send_beat(directed[i]);

        // random phase: table fills to overflow, and mixed traffic
        sent = 0;
        while (sent < N_RANDOM) begin
            if (sent == 0 || $urandom_range(0, 5) == 0) begin
                send_beat(rand_item(CMD_CLEAR, 0));
                sent++;
                while (mdl_pairs.size() < PAIR_CAPACITY) begin
                    if ($urandom_range(0, 9) == 0 && mdl_pairs.size() > 0) begin
                        it = rand_item(CMD_PAIR, 0);
                        rnd = $urandom_range(0, mdl_pairs.size() - 1);
                        {it.id_a, it.id_b} = mdl_pairs[rnd];
                        if ($urandom_range(0, 1)) {it.id_a, it.id_b} = {it.id_b, it.id_a};
                        send_beat(it);
                    end else begin
                        send_beat(rand_item(CMD_PAIR, 0));
                    end
                    sent++;
                end
                // full table: new pairs flagged, stored ones still duplicates
                repeat (12) begin
                    it = rand_item(CMD_PAIR, 0);
                    if ($urandom_range(0, 1)) begin
                        rnd = $urandom_range(0, mdl_pairs.size() - 1);
                        {it.id_a, it.id_b} = mdl_pairs[rnd];
                        if ($urandom_range(0, 1)) {it.id_a, it.id_b} = {it.id_b, it.id_a};
                    end
                    send_beat(it);
                    sent++;
                end
            end else begin
                repeat (60) begin
                    rnd = $urandom_range(0, 99);
                    if (rnd < 45)      it = rand_item(CMD_ADD, 0);
                    else if (rnd < 88) it = rand_item(CMD_PAIR, 15);
                    else if (rnd < 94) it = rand_item(CMD_CLEAR, 0);
                    else               it = rand_item(CMD_NONE, 0);
                    send_beat(it);
                    sent++;
                end
            end
        end

        // drain
        while (tensor_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (err_cnt == 0)
            $display("[pair_deduplicated_stress_tensor_top] OK");
        else
            $display("[pair_deduplicated_stress_tensor_top] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/pdst_pkg.sv
rtl/pdst_cell.sv
rtl/pdst_mac.sv
rtl/pair_deduplicated_stress_tensor_top.sv
sim/tb_pair_deduplicated_stress_tensor_top.sv
